// ===== hdl/dirty_rectangle_tracker_macros.svh =====
`ifndef DIRTY_RECTANGLE_TRACKER_MACROS_SVH
`define DIRTY_RECTANGLE_TRACKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define DRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define DRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/drt_pkg.sv =====
package drt_pkg;

	localparam int MAX_REGIONS_DEF = 16;
	localparam int COORD_W         = 16;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	// register index, taken from paddr[2]
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		MODE_MARK  = 2'd0,
		MODE_FULL  = 2'd1,
		MODE_READ  = 2'd2,
		MODE_FLUSH = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STAT_IGNORED  = 3'd0,
		STAT_MERGED   = 3'd1,
		STAT_APPENDED = 3'd2,
		STAT_OVERFLOW = 3'd3,
		STAT_DONE     = 3'd4
	} status_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
	} region_t;

	localparam int REGION_W = $bits(region_t);

endpackage

// ===== hdl/drt_if.sv =====
interface drt_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] rect_left;
	logic [15:0] rect_top;
	logic [15:0] rect_width;
	logic [15:0] rect_height;
	logic [3:0]  read_slot;

	modport source (
		output valid, mode, rect_left, rect_top, rect_width, rect_height, read_slot,
		input  ready
	);
	modport sink (
		input  valid, mode, rect_left, rect_top, rect_width, rect_height, read_slot,
		output ready
	);
endinterface

interface drt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  slot;
	logic [15:0] out_left;
	logic [15:0] out_top;
	logic [15:0] out_width;
	logic [15:0] out_height;
	logic [4:0]  stored_count;
	logic        redraw_all;

	modport source (
		output valid, status, slot, out_left, out_top, out_width, out_height,
		       stored_count, redraw_all,
		input  ready
	);
	modport sink (
		input  valid, status, slot, out_left, out_top, out_width, out_height,
		       stored_count, redraw_all,
		output ready
	);
endinterface

// ===== hdl/drt_ram.sv =====
module drt_ram #(
	parameter int WIDTH = drt_pkg::REGION_W,
	parameter int DEPTH = drt_pkg::MAX_REGIONS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/dirty_rectangle_tracker.sv =====
// From accept to result register, control transactions, ignored marks and reads past the
// count pass execute and result load; a read adds a RAM read; a mark passes clip, scan
// start, one compare per stored entry up to the first hit through the single RAM read port,
// write back and result load (the scan is skipped when the list is empty). One transaction
// in flight; the next is accepted once its result is loaded, even while it waits there.
// Reset clears entry count, full-redraw flag and screen bounds; RAM is not cleared.
`include "dirty_rectangle_tracker_macros.svh"

module dirty_rectangle_tracker #(
	parameter int MAX_REGIONS = drt_pkg::MAX_REGIONS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [drt_pkg::PADDR_W-1:0] paddr,
	input  logic [drt_pkg::PDATA_W-1:0] pwdata,
	output logic [drt_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	drt_cmd_if.sink                     cmd,
	drt_rsp_if.source                   rsp
);

	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam int XW = drt_pkg::COORD_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_MERGE,
		S_APPEND,
		S_RD_DONE,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] sw_q, sh_q;

	// latched request
	drt_pkg::mode_t mode_q;
	logic [15:0]    x_q, y_q, w_q, h_q;
	logic [3:0]     rs_q;
	logic [XW-1:0]  rr_q, rb_q;

	// list state
	logic [CW-1:0] count_q;
	logic          flag_q;

	// scan pipeline
	logic [CW-1:0] rd_idx_q;
	logic          pend_s1;
	logic [IW-1:0] idx_s1;
	logic [IW-1:0] hit_idx_q;
	drt_pkg::region_t hit_q;

	// pending result
	drt_pkg::status_t res_status_q;
	logic [3:0]       res_slot_q;
	drt_pkg::region_t res_rect_q;

	// output register
	logic             out_valid_q;
	logic [2:0]       out_status_q;
	logic [3:0]       out_slot_q;
	drt_pkg::region_t out_rect_q;
	logic [4:0]       out_count_q;
	logic             out_flag_q;

	// RAM port
	logic                          ram_we;
	logic [IW-1:0]                 ram_waddr, ram_raddr;
	logic [drt_pkg::REGION_W-1:0]  ram_wdata, ram_rdata;
	drt_pkg::region_t              rd_rect;
	drt_pkg::region_t              req_rect, merged_rect;

	// ---------------------------------------------------------------- config port
	logic cfg_wr;
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= '0;
			sh_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				drt_pkg::REG_SCREEN_WIDTH:  sw_q <= pwdata[15:0];
				drt_pkg::REG_SCREEN_HEIGHT: sh_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			drt_pkg::REG_SCREEN_WIDTH:  prdata = {16'b0, sw_q};
			drt_pkg::REG_SCREEN_HEIGHT: prdata = {16'b0, sh_q};
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- clipping
	logic          on_screen;
	logic [XW-1:0] xe, ye;
	logic          x_over, y_over;
	logic [15:0]   clip_w, clip_h;
	logic [XW-1:0] clip_r, clip_b;

	always_comb begin
		on_screen = !flag_q && (x_q < sw_q) && (y_q < sh_q);
		xe        = {1'b0, x_q} + {1'b0, w_q};
		ye        = {1'b0, y_q} + {1'b0, h_q};
		x_over    = xe > {1'b0, sw_q};
		y_over    = ye > {1'b0, sh_q};
		clip_w    = x_over ? (sw_q - x_q) : w_q;
		clip_h    = y_over ? (sh_q - y_q) : h_q;
		clip_r    = x_over ? {1'b0, sw_q} : xe;
		clip_b    = y_over ? {1'b0, sh_q} : ye;
	end

	// ---------------------------------------------------------------- scan compare
	logic [XW-1:0] rd_er, rd_eb;
	logic          rd_apart, scan_hit, scan_last, scan_issue;

	assign rd_rect = drt_pkg::region_t'(ram_rdata);

	always_comb begin
		rd_er      = {1'b0, rd_rect.left} + {1'b0, rd_rect.width};
		rd_eb      = {1'b0, rd_rect.top} + {1'b0, rd_rect.height};
		rd_apart   = ({1'b0, rd_rect.left} > rr_q) || ({1'b0, x_q} > rd_er) ||
		             ({1'b0, rd_rect.top} > rb_q) || ({1'b0, y_q} > rd_eb);
		scan_hit   = pend_s1 && !rd_apart;
		scan_last  = (CW'(idx_s1) + CW'(1)) == count_q;
		scan_issue = rd_idx_q < count_q;
	end

	// ---------------------------------------------------------------- merge
	logic [XW-1:0] m_er, m_eb, m_x1, m_y1;
	logic [15:0]   m_x0, m_y0;
	logic [XW-1:0] m_w, m_h;

	always_comb begin
		m_er = {1'b0, hit_q.left} + {1'b0, hit_q.width};
		m_eb = {1'b0, hit_q.top} + {1'b0, hit_q.height};
		m_x0 = (hit_q.left < x_q) ? hit_q.left : x_q;
		m_y0 = (hit_q.top < y_q) ? hit_q.top : y_q;
		m_x1 = (m_er > rr_q) ? m_er : rr_q;
		m_y1 = (m_eb > rb_q) ? m_eb : rb_q;
		m_w  = m_x1 - {1'b0, m_x0};
		m_h  = m_y1 - {1'b0, m_y0};
		merged_rect.left   = m_x0;
		merged_rect.top    = m_y0;
		merged_rect.width  = m_w[15:0];
		merged_rect.height = m_h[15:0];
		req_rect.left      = x_q;
		req_rect.top       = y_q;
		req_rect.width     = w_q;
		req_rect.height    = h_q;
	end

	// ---------------------------------------------------------------- region RAM
	logic room;
	assign room = count_q < CW'(MAX_REGIONS);

	always_comb begin
		ram_we    = (state_q == S_MERGE) || ((state_q == S_APPEND) && room);
		ram_waddr = (state_q == S_MERGE) ? hit_idx_q : count_q[IW-1:0];
		ram_wdata = (state_q == S_MERGE) ? merged_rect : req_rect;
		ram_raddr = (state_q == S_EXEC) ? IW'(rs_q) : rd_idx_q[IW-1:0];
	end

	drt_ram #(
		.WIDTH (drt_pkg::REGION_W),
		.DEPTH (MAX_REGIONS)
	) u_region_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- control
	logic out_free;
	logic load_out;
	assign out_free  = !out_valid_q || rsp.ready;
	assign load_out  = (state_q == S_OUT) && out_free;
	assign cmd.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			flag_q       <= 1'b0;
			pend_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
			mode_q       <= drt_pkg::MODE_MARK;
			x_q          <= '0;
			y_q          <= '0;
			w_q          <= '0;
			h_q          <= '0;
			rs_q         <= '0;
			rr_q         <= '0;
			rb_q         <= '0;
			rd_idx_q     <= '0;
			idx_s1       <= '0;
			hit_idx_q    <= '0;
			hit_q        <= '0;
			res_status_q <= drt_pkg::STAT_IGNORED;
			res_slot_q   <= '0;
			res_rect_q   <= '0;
			out_status_q <= '0;
			out_slot_q   <= '0;
			out_rect_q   <= '0;
			out_count_q  <= '0;
			out_flag_q   <= 1'b0;
		end else begin
			if (rsp.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						mode_q  <= drt_pkg::mode_t'(cmd.mode);
						x_q     <= cmd.rect_left;
						y_q     <= cmd.rect_top;
						w_q     <= cmd.rect_width;
						h_q     <= cmd.rect_height;
						rs_q    <= cmd.read_slot;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_status_q <= drt_pkg::STAT_IGNORED;
					res_slot_q   <= '0;
					res_rect_q   <= '0;
					case (mode_q)
						drt_pkg::MODE_MARK: begin
							if (on_screen && (clip_w != '0) && (clip_h != '0)) begin
								w_q      <= clip_w;
								h_q      <= clip_h;
								rr_q     <= clip_r;
								rb_q     <= clip_b;
								rd_idx_q <= '0;
								pend_s1  <= 1'b0;
								state_q  <= (count_q == '0) ? S_APPEND : S_SCAN;
							end else begin
								state_q <= S_OUT;
							end
						end
						drt_pkg::MODE_FULL: begin
							flag_q       <= 1'b1;
							res_status_q <= drt_pkg::STAT_DONE;
							state_q      <= S_OUT;
						end
						drt_pkg::MODE_READ: begin
							// RAM read of rs_q is issued this cycle
							if (32'(rs_q) < 32'(count_q)) begin
								res_status_q <= drt_pkg::STAT_DONE;
								res_slot_q   <= rs_q;
								state_q      <= S_RD_DONE;
							end else begin
								state_q <= S_OUT;
							end
						end
						drt_pkg::MODE_FLUSH: begin
							count_q      <= '0;
							flag_q       <= 1'b0;
							res_status_q <= drt_pkg::STAT_DONE;
							state_q      <= S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_SCAN: begin
					// one read issued per cycle, compared in the following cycle
					if (scan_hit) begin
						hit_q     <= rd_rect;
						hit_idx_q <= idx_s1;
						pend_s1   <= 1'b0;
						state_q   <= S_MERGE;
					end else if (pend_s1 && scan_last) begin
						pend_s1 <= 1'b0;
						state_q <= S_APPEND;
					end else begin
						pend_s1 <= scan_issue;
						idx_s1  <= rd_idx_q[IW-1:0];
						if (scan_issue) begin
							rd_idx_q <= rd_idx_q + CW'(1);
						end
					end
				end
				S_MERGE: begin
					res_status_q <= drt_pkg::STAT_MERGED;
					res_slot_q   <= 4'(hit_idx_q);
					res_rect_q   <= merged_rect;
					state_q      <= S_OUT;
				end
				S_APPEND: begin
					res_rect_q <= req_rect;
					if (room) begin
						res_status_q <= drt_pkg::STAT_APPENDED;
						res_slot_q   <= 4'(count_q);
						count_q      <= count_q + CW'(1);
					end else begin
						res_status_q <= drt_pkg::STAT_OVERFLOW;
						res_slot_q   <= '0;
						flag_q       <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_RD_DONE: begin
					res_rect_q <= rd_rect;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						out_rect_q   <= res_rect_q;
						out_count_q  <= 5'(count_q);
						out_flag_q   <= flag_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.slot         = out_slot_q;
	assign rsp.out_left     = out_rect_q.left;
	assign rsp.out_top      = out_rect_q.top;
	assign rsp.out_width    = out_rect_q.width;
	assign rsp.out_height   = out_rect_q.height;
	assign rsp.stored_count = out_count_q;
	assign rsp.redraw_all   = out_flag_q;

	// ---------------------------------------------------------------- assertions
	`DRT_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(MAX_REGIONS), "entry count above capacity")
	`DRT_ASSERT_NOW(a_scan_in_list, clk, arst_n, pend_s1, CW'(idx_s1) < count_q, "scan compare beyond entry count")
	`DRT_ASSERT_NEXT(a_result_loaded, clk, arst_n, (state_q == S_OUT) && out_free, rsp.valid, "result not presented")
	`DRT_ASSERT_NOW(a_ram_write_state, clk, arst_n, ram_we, (state_q == S_MERGE) || (state_q == S_APPEND), "RAM write outside merge or append")

endmodule

// ===== verif/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import drt_pkg::*;

	localparam int SETTLE_CYCLES = 32;
	localparam int PHASES        = 9;
	localparam int PHASE_ITEMS   = 165;
	localparam logic [PADDR_W-1:0] ADDR_WIDTH  = {REG_SCREEN_WIDTH, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_HEIGHT = {REG_SCREEN_HEIGHT, 2'b00};

	typedef struct {
		status_t     status;
		logic [3:0]  slot;
		region_t     box;
		logic [4:0]  count;
		logic        redraw;
	} dirty_rsp_t;

	typedef enum {ROW_ITEM, ROW_BOUNDS} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		mode_t       mode;
		region_t     box;
		logic [3:0]  rslot;
		bit          typed;
		dirty_rsp_t  want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;
	logic pready;

	drt_cmd_if cmd_ch ();
	drt_rsp_if rsp_ch ();

	dirty_rectangle_tracker uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch)
	);

	// shadow of the tracker state
	int unsigned scr_w, scr_h;
	region_t     shadow_regions [MAX_REGIONS_DEF];
	int          region_cnt;
	bit          redraw_pending;

	dirty_rsp_t  awaited_rsp [$];
	stim_row_t   stim_rows [$];
	int          mismatches;
	int          src_idle_pct;
	int          sink_stall_pct;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);
	end

	task automatic report_error(string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		dirty_rsp_t w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_rsp.size() == 0) begin
				report_error("result with no transaction outstanding");
			end else begin
				w = awaited_rsp.pop_front();
				check_field("status", 16'(rsp_ch.status), 16'(w.status));
				check_field("slot", 16'(rsp_ch.slot), 16'(w.slot));
				check_field("out_left", rsp_ch.out_left, w.box.left);
				check_field("out_top", rsp_ch.out_top, w.box.top);
				check_field("out_width", rsp_ch.out_width, w.box.width);
				check_field("out_height", rsp_ch.out_height, w.box.height);
				check_field("stored_count", 16'(rsp_ch.stored_count), 16'(w.count));
				check_field("redraw_all", 16'(rsp_ch.redraw_all), 16'(w.redraw));
			end
		end
	end

	// one list update for any mode; a mark clips, merges into first touching entry, appends or overflows
	function automatic dirty_rsp_t dirty_list_step(mode_t m, region_t req, logic [3:0] rs);
		dirty_rsp_t o;
		region_t clip;
		int unsigned x, y, w, h, el, et, er, eb, x0, y0, x1, y1;
		bit hit;
		int i;
		o.status = STAT_IGNORED;
		o.slot   = '0;
		o.box    = '0;
		x = req.left;
		y = req.top;
		w = req.width;
		h = req.height;
		hit = 1'b0;
		case (m)
		MODE_MARK: begin
			if (!redraw_pending && x < scr_w && y < scr_h) begin
				if (x + w > scr_w)
					w = scr_w - x;
				if (y + h > scr_h)
					h = scr_h - y;
				if (w != 0 && h != 0) begin
					clip.left   = x[15:0];
					clip.top    = y[15:0];
					clip.width  = w[15:0];
					clip.height = h[15:0];
					for (i = 0; i < region_cnt; i++) begin
						el = shadow_regions[i].left;
						et = shadow_regions[i].top;
						er = el + shadow_regions[i].width;
						eb = et + shadow_regions[i].height;
						// touching edges count as overlap
						if (!hit && !(el > x + w || x > er || et > y + h || y > eb)) begin
							hit = 1'b1;
							x0 = (el < x) ? el : x;
							y0 = (et < y) ? et : y;
							x1 = (er > x + w) ? er : x + w;
							y1 = (eb > y + h) ? eb : y + h;
							shadow_regions[i].left   = x0[15:0];
							shadow_regions[i].top    = y0[15:0];
							shadow_regions[i].width  = 16'(x1 - x0);
							shadow_regions[i].height = 16'(y1 - y0);
							o.status = STAT_MERGED;
							o.slot   = i[3:0];
							o.box    = shadow_regions[i];
						end
					end
					if (!hit) begin
						if (region_cnt < MAX_REGIONS_DEF) begin
							shadow_regions[region_cnt] = clip;
							o.slot   = region_cnt[3:0];
							o.status = STAT_APPENDED;
							region_cnt++;
						end else begin
							redraw_pending = 1'b1;
							o.status = STAT_OVERFLOW;
						end
						o.box = clip;
					end
				end
			end
		end
		MODE_FULL: begin
			redraw_pending = 1'b1;
			o.status = STAT_DONE;
		end
		MODE_READ: begin
			if (int'(rs) < region_cnt) begin
				o.status = STAT_DONE;
				o.slot   = rs;
				o.box    = shadow_regions[rs];
			end
		end
		default: begin
			region_cnt = 0;
			redraw_pending = 1'b0;
			o.status = STAT_DONE;
		end
		endcase
		o.count  = region_cnt[4:0];
		o.redraw = redraw_pending;
		return o;
	endfunction

	task automatic apb_xfer(input bit wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = addr;
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic wait_drained();
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_bounds(int unsigned w, int unsigned h);
		logic [PDATA_W-1:0] rd;
		wait_drained();
		apb_xfer(1'b1, ADDR_WIDTH, PDATA_W'(w), rd);
		apb_xfer(1'b1, ADDR_HEIGHT, PDATA_W'(h), rd);
		scr_w = w;
		scr_h = h;
		apb_xfer(1'b0, ADDR_WIDTH, '0, rd);
		if (rd !== PDATA_W'(w))
			report_error($sformatf("screen_width readback %0h want %0h", rd, w));
		apb_xfer(1'b0, ADDR_HEIGHT, '0, rd);
		if (rd !== PDATA_W'(h))
			report_error($sformatf("screen_height readback %0h want %0h", rd, h));
	endtask

	// drive one transaction, then queue its predicted or hand-written result
	task automatic offer_item(mode_t m, region_t b, logic [3:0] rs, bit typed,
			dirty_rsp_t want);
		int gap;
		dirty_rsp_t pred;
		gap = 0;
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
			gap++;
		@(negedge clk);
		if (gap != 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.mode        = m;
		cmd_ch.rect_left   = b.left;
		cmd_ch.rect_top    = b.top;
		cmd_ch.rect_width  = b.width;
		cmd_ch.rect_height = b.height;
		cmd_ch.read_slot   = rs;
		cmd_ch.valid       = 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pred = dirty_list_step(m, b, rs);
		awaited_rsp.push_back(typed ? want : pred);
	endtask

	function automatic region_t mk_box(int l, int t, int w, int h);
		region_t b;
		b.left   = 16'(l);
		b.top    = 16'(t);
		b.width  = 16'(w);
		b.height = 16'(h);
		return b;
	endfunction

	function automatic void plan_item(mode_t m, int l, int t, int w, int h, int rs);
		stim_row_t r;
		r.kind  = ROW_ITEM;
		r.mode  = m;
		r.box   = mk_box(l, t, w, h);
		r.rslot = 4'(rs);
		r.typed = 1'b0;
		r.want.status = STAT_IGNORED;
		r.want.slot   = '0;
		r.want.box    = '0;
		r.want.count  = '0;
		r.want.redraw = 1'b0;
		stim_rows.push_back(r);
	endfunction

	function automatic void plan_known(mode_t m, int l, int t, int w, int h, int rs,
			status_t st, int sl, region_t ebox, int cnt, bit rd);
		plan_item(m, l, t, w, h, rs);
		stim_rows[$].typed       = 1'b1;
		stim_rows[$].want.status = st;
		stim_rows[$].want.slot   = 4'(sl);
		stim_rows[$].want.box    = ebox;
		stim_rows[$].want.count  = 5'(cnt);
		stim_rows[$].want.redraw = rd;
	endfunction

	function automatic void plan_bounds(int w, int h);
		plan_item(MODE_MARK, 0, 0, w, h, 0);
		stim_rows[$].kind = ROW_BOUNDS;
	endfunction

	task automatic pick_random(output mode_t m, output region_t b, output logic [3:0] rs);
		int unsigned sel, span_x, span_y, sz;
		sel = $urandom_range(0, 99);
		rs  = 4'($urandom_range(0, 15));
		b   = {$urandom(), $urandom()};
		if (sel < 2) begin
			m = MODE_FLUSH;
		end else if (sel < 3) begin
			m = MODE_FULL;
		end else if (sel < 13) begin
			m = MODE_READ;
		end else begin
			m = MODE_MARK;
			// marks from 91 up keep fully random fields
			if (sel < 91) begin
				span_x = (scr_w < 256) ? scr_w : 256;
				span_y = (scr_h < 256) ? scr_h : 256;
				if (scr_w != 0)
					b.left = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, scr_w - 1))
						: 16'($urandom_range(0, span_x - 1));
				if (scr_h != 0)
					b.top = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, scr_h - 1))
						: 16'($urandom_range(0, span_y - 1));
				if ($urandom_range(0, 29) == 0)
					b.left = 16'(scr_w);
				if ($urandom_range(0, 29) == 0)
					b.top = 16'(scr_h);
				sz = $urandom_range(0, 19);
				if (sz < 14) begin
					b.width  = 16'($urandom_range(1, 16));
					b.height = 16'($urandom_range(1, 16));
				end else if (sz < 17) begin
					b.width  = 16'($urandom_range(0, 65535));
					b.height = 16'($urandom_range(0, 65535));
				end else begin
					b.width  = 16'($urandom_range(0, 3));
					b.height = 16'($urandom_range(0, 3));
				end
			end
		end
	endtask

	initial begin
		stim_row_t  row;
		mode_t      m;
		region_t    b;
		logic [3:0] rs;
		dirty_rsp_t none;
		int         ph, n;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_MARK;
		cmd_ch.rect_left = '0;
		cmd_ch.rect_top = '0;
		cmd_ch.rect_width = '0;
		cmd_ch.rect_height = '0;
		cmd_ch.read_slot = '0;
		rsp_ch.ready = 1'b0;
		mismatches = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		scr_w = 0;
		scr_h = 0;
		region_cnt = 0;
		redraw_pending = 1'b0;
		foreach (shadow_regions[i])
			shadow_regions[i] = '0;
		none = dirty_list_step(MODE_READ, '0, 4'd0);

		// bounds are zero out of reset, so nothing can be marked
		plan_known(MODE_MARK, 0, 0, 10, 10, 0, STAT_IGNORED, 0, '0, 0, 0);
		plan_known(MODE_READ, 0, 0, 0, 0, 0, STAT_IGNORED, 0, '0, 0, 0);
		plan_known(MODE_FLUSH, 0, 0, 0, 0, 0, STAT_DONE, 0, '0, 0, 0);
		plan_bounds(100, 50);
		plan_known(MODE_MARK, 10, 10, 20, 20, 0, STAT_APPENDED, 0,
			mk_box(10, 10, 20, 20), 1, 0);
		plan_item(MODE_MARK, 30, 10, 5, 5, 0);                   // touches right edge
		plan_known(MODE_MARK, 100, 0, 5, 5, 0, STAT_IGNORED, 0, '0, 1, 0);
		plan_known(MODE_MARK, 0, 50, 5, 5, 0, STAT_IGNORED, 0, '0, 1, 0);
		plan_item(MODE_MARK, 90, 40, 65535, 65535, 0);           // clipped both ways
		plan_known(MODE_MARK, 5, 5, 0, 10, 0, STAT_IGNORED, 0, '0, 2, 0);
		plan_item(MODE_MARK, 0, 0, 1, 1, 0);
		plan_item(MODE_READ, 0, 0, 0, 0, 1);
		plan_known(MODE_READ, 0, 0, 0, 0, 15, STAT_IGNORED, 0, '0, 3, 0);
		plan_known(MODE_FULL, 65535, 65535, 65535, 65535, 15, STAT_DONE, 0, '0, 3, 1);
		plan_known(MODE_MARK, 1, 1, 2, 2, 0, STAT_IGNORED, 0, '0, 3, 1);
		plan_item(MODE_READ, 0, 0, 0, 0, 0);                     // list kept under redraw
		plan_known(MODE_FLUSH, 0, 0, 0, 0, 0, STAT_DONE, 0, '0, 0, 0);
		plan_bounds(65535, 65535);
		plan_known(MODE_MARK, 65534, 65534, 65535, 65535, 0, STAT_APPENDED, 0,
			mk_box(65534, 65534, 1, 1), 1, 0);
		plan_item(MODE_MARK, 0, 0, 65535, 65535, 0);
		plan_known(MODE_MARK, 65535, 0, 1, 1, 0, STAT_IGNORED, 0, '0, 1, 0);
		plan_bounds(1, 1);
		plan_known(MODE_MARK, 0, 0, 0, 1, 0, STAT_IGNORED, 0, '0, 1, 0);
		plan_known(MODE_FLUSH, 0, 0, 0, 0, 0, STAT_DONE, 0, '0, 0, 0);
		plan_known(MODE_MARK, 0, 0, 65535, 65535, 0, STAT_APPENDED, 0,
			mk_box(0, 0, 1, 1), 1, 0);
		plan_known(MODE_READ, 0, 0, 0, 0, 0, STAT_DONE, 0, mk_box(0, 0, 1, 1), 1, 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[k]) begin
			row = stim_rows[k];
			if (row.kind == ROW_BOUNDS) begin
				@(negedge clk);
				cmd_ch.valid = 1'b0;
				set_bounds(row.box.width, row.box.height);
			end else begin
				offer_item(row.mode, row.box, row.rslot, row.typed, row.want);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			@(negedge clk);
			cmd_ch.valid = 1'b0;
			case (ph)
			0: set_bounds(640, 480);
			1: set_bounds(65535, 65535);
			2: set_bounds(48, 32);
			3: set_bounds(1, 65535);
			4: set_bounds(320, 240);
			5: set_bounds(0, 0);
			6: set_bounds($urandom_range(1, 65535), $urandom_range(1, 65535));
			7: set_bounds(65535, 1);
			default: set_bounds(200, 150);
			endcase
			src_idle_pct   = (ph % 4 == 1) ? 68 : (ph % 4 == 3) ? 7 : 0;
			sink_stall_pct = (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 7 : 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick_random(m, b, rs);
				offer_item(m, b, rs, 1'b0, none);
			end
		end

		@(negedge clk);
		cmd_ch.valid = 1'b0;
		wait_drained();
		if (mismatches == 0 && awaited_rsp.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
